>>> sv/ccre_pkg.sv
// shared codes and widths for the character canvas raster engine
`default_nettype none
package ccre_pkg;
  localparam int REQ_W    = 3;
  localparam int COORD_W  = 8;
  localparam int SPAN_W   = 7;
  localparam int SYM_W    = 8;
  localparam int CNT_W    = 7;
  localparam int STATUS_W = 2;

  localparam logic [REQ_W-1:0] REQ_RESIZE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FILL   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_RECT   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_FLIP_V = 3'd3;
  localparam logic [REQ_W-1:0] REQ_FLIP_H = 3'd4;
  localparam logic [REQ_W-1:0] REQ_ROTATE = 3'd5;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SAT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef logic [SYM_W-1:0] sym_t;
endpackage
`default_nettype wire

>>> sv/ccre_ram.sv
// generic single write port ram with registered read
`default_nettype none
module ccre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> sv/char_canvas_raster_engine.sv
// top level: command sequencer, shared address unit and the two canvas rams
// resize/fill and rectangle write each covered cell in turn; flips read both
// cells of each swapped pair and write them back swapped; rotate copies every
// cell to scratch and back in two passes; read fetches one cell from the canvas
// busy stays high until the result; done pulses one cycle with the result word
// rst clears the canvas extents to zero and returns to idle; ram contents are not cleared
`default_nettype none
module char_canvas_raster_engine
  import ccre_pkg::*;
#(
  parameter int CANVAS_SIDE = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [REQ_W-1:0]    req_type,
  input  wire logic signed [COORD_W-1:0] origin_row,
  input  wire logic signed [COORD_W-1:0] origin_col,
  input  wire logic [SPAN_W-1:0]   span_cols,
  input  wire logic [SPAN_W-1:0]   span_rows,
  input  wire logic [SYM_W-1:0]    symbol,
  output logic                     done,
  output logic [SYM_W-1:0]         cell_value,
  output logic [CNT_W-1:0]         row_count,
  output logic [CNT_W-1:0]         col_count,
  output logic [STATUS_W-1:0]      status
);
  localparam int DEPTH = CANVAS_SIDE * CANVAS_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(CANVAS_SIDE + 1);
  localparam int IW    = $clog2(CANVAS_SIDE);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic              state;
  logic              live;     // high while cells are left to walk
  logic              pass;     // rotate: 0 canvas->scratch, 1 scratch->canvas
  logic [REQ_W-1:0]  op;
  logic [1:0]        ph;
  logic [CW-1:0]     r, c, c_lo, r_hi, c_hi;
  logic [CW-1:0]     rows, cols;
  sym_t              sym, da, rd_sym;
  logic [STATUS_W-1:0] stat;
  logic [AW-1:0]     addr_a, addr_b;

  // shared address unit
  logic [CW-1:0]     ar, ac;
  logic [AW-1:0]     addr;

  // ram ports
  logic              cv_we, sc_we;
  logic [AW-1:0]     cv_waddr;
  sym_t              cv_wdata, cv_rdata, sc_rdata;

  // command decode at accept
  int                r0i, c0i, rhi, chi;
  logic              rect_empty, read_bad, sat_r, sat_c;
  logic [CW-1:0]     new_rows, new_cols;

  logic              is_fill, is_flip, is_rot;
  logic [1:0]        ph_last;
  logic [CW:0]       c_inc, r_inc;

  assign busy  = (state != S_IDLE);
  assign is_fill = (op == REQ_RESIZE) || (op == REQ_FILL) || (op == REQ_RECT);
  assign is_flip = (op == REQ_FLIP_V) || (op == REQ_FLIP_H);
  assign is_rot  = (op == REQ_ROTATE);
  assign c_inc = {1'b0, c} + 1'b1;
  assign r_inc = {1'b0, r} + 1'b1;

  always_comb begin
    case (op)
      REQ_FLIP_V, REQ_FLIP_H: ph_last = 2'd3;
      REQ_ROTATE, REQ_READ:   ph_last = 2'd1;
      default:                ph_last = 2'd0;
    endcase
  end

  always_comb begin
    r0i = origin_row[COORD_W-1] ? 0 : int'(origin_row[COORD_W-2:0]);
    c0i = origin_col[COORD_W-1] ? 0 : int'(origin_col[COORD_W-2:0]);
    rhi = r0i + int'(span_rows);
    chi = c0i + int'(span_cols);
    if (rhi > int'(rows)) rhi = int'(rows);
    if (chi > int'(cols)) chi = int'(cols);
    rect_empty = (r0i >= rhi) || (c0i >= chi);
    read_bad = origin_row[COORD_W-1] || origin_col[COORD_W-1] ||
               (int'(origin_row[COORD_W-2:0]) >= int'(rows)) ||
               (int'(origin_col[COORD_W-2:0]) >= int'(cols));
    sat_r = int'(span_rows) > CANVAS_SIDE;
    sat_c = int'(span_cols) > CANVAS_SIDE;
    new_rows = sat_r ? CW'(CANVAS_SIDE) : CW'(span_rows);
    new_cols = sat_c ? CW'(CANVAS_SIDE) : CW'(span_cols);
  end

  // operand select for the address unit
  always_comb begin
    ar = r;
    ac = c;
    if (ph == 2'd1) begin
      case (op)
        REQ_FLIP_V: ar = rows - 1'b1 - r;
        REQ_FLIP_H: ac = cols - 1'b1 - c;
        REQ_ROTATE: begin
          if (!pass) begin
            ar = c;
            ac = rows - 1'b1 - r;
          end
        end
        default: ;
      endcase
    end
  end

  assign addr = AW'(ar[IW-1:0]) * AW'(CANVAS_SIDE) + AW'(ac[IW-1:0]);

  // write port control
  always_comb begin
    cv_we    = 1'b0;
    sc_we    = 1'b0;
    cv_waddr = addr;
    cv_wdata = sym;
    if (state == S_RUN && live) begin
      if (is_fill) begin
        cv_we = (ph == 2'd0);
      end else if (is_flip) begin
        cv_we = ph[1];
        cv_waddr = ph[0] ? addr_b : addr_a;
        cv_wdata = ph[0] ? da : cv_rdata;
      end else if (is_rot) begin
        cv_we = pass && (ph == 2'd1);
        sc_we = !pass && (ph == 2'd1);
        cv_wdata = sc_rdata;
      end
    end
  end

  ccre_ram #(.WIDTH(SYM_W), .DEPTH(DEPTH)) u_canvas (
    .clk(clk), .we(cv_we), .waddr(cv_waddr), .wdata(cv_wdata),
    .raddr(addr), .rdata(cv_rdata)
  );

  ccre_ram #(.WIDTH(SYM_W), .DEPTH(DEPTH)) u_scratch (
    .clk(clk), .we(sc_we), .waddr(addr), .wdata(cv_rdata),
    .raddr(addr), .rdata(sc_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      live  <= 1'b0;
      done  <= 1'b0;
      rows  <= '0;
      cols  <= '0;
      ph    <= '0;
      pass  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_RUN;
            op    <= req_type;
            sym   <= symbol;
            stat  <= ST_OK;
            rd_sym <= '0;
            ph    <= '0;
            pass  <= 1'b0;
            r     <= '0;
            c     <= '0;
            c_lo  <= '0;
            r_hi  <= rows;
            c_hi  <= cols;
            live  <= (rows != '0) && (cols != '0);
            case (req_type)
              REQ_RESIZE: begin
                rows <= new_rows;
                cols <= new_cols;
                r_hi <= new_rows;
                c_hi <= new_cols;
                live <= (new_rows != '0) && (new_cols != '0);
                if (sat_r || sat_c) stat <= ST_SAT;
              end
              REQ_FILL, REQ_ROTATE: ;
              REQ_RECT: begin
                r    <= CW'(r0i);
                c    <= CW'(c0i);
                c_lo <= CW'(c0i);
                r_hi <= CW'(rhi);
                c_hi <= CW'(chi);
                live <= !rect_empty;
              end
              REQ_FLIP_V: begin
                r_hi <= rows >> 1;
                live <= (rows > CW'(1)) && (cols != '0);
              end
              REQ_FLIP_H: begin
                c_hi <= cols >> 1;
                live <= (rows != '0) && (cols > CW'(1));
              end
              REQ_READ: begin
                r    <= CW'(origin_row[COORD_W-2:0]);
                c    <= CW'(origin_col[COORD_W-2:0]);
                c_lo <= CW'(origin_col[COORD_W-2:0]);
                r_hi <= CW'(origin_row[COORD_W-2:0]) + 1'b1;
                c_hi <= CW'(origin_col[COORD_W-2:0]) + 1'b1;
                live <= !read_bad;
                if (read_bad) stat <= ST_RANGE;
              end
              default: live <= 1'b0;
            endcase
          end
        end
        S_RUN: begin
          if (!live) begin
            // result word
            state <= S_IDLE;
            done  <= 1'b1;
            cell_value <= rd_sym;
            status     <= stat;
            if (is_rot) begin
              rows <= cols;
              cols <= rows;
              row_count <= CNT_W'(cols);
              col_count <= CNT_W'(rows);
            end else begin
              row_count <= CNT_W'(rows);
              col_count <= CNT_W'(cols);
            end
          end else begin
            if (ph == 2'd0) addr_a <= addr;
            if (ph == 2'd1) begin
              addr_b <= addr;
              da     <= cv_rdata;
              if (op == REQ_READ) rd_sym <= cv_rdata;
            end
            if (ph == ph_last) begin
              ph <= '0;
              if (c_inc < {1'b0, c_hi}) begin
                c <= c_inc[CW-1:0];
              end else begin
                c <= c_lo;
                if (r_inc < {1'b0, r_hi}) begin
                  r <= r_inc[CW-1:0];
                end else if (is_rot && !pass) begin
                  // second pass copies scratch back with swapped extents
                  pass <= 1'b1;
                  r    <= '0;
                  c    <= '0;
                  c_lo <= '0;
                  r_hi <= cols;
                  c_hi <= rows;
                end else begin
                  live <= 1'b0;
                end
              end
            end else begin
              ph <= ph + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result word while busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command not taken");
  a_one_writer: assert property (@(posedge clk) disable iff (rst) !(cv_we && sc_we))
    else $error("both rams written at once");
  a_counts: assert property (@(posedge clk) disable iff (rst)
    (int'(rows) <= CANVAS_SIDE) && (int'(cols) <= CANVAS_SIDE))
    else $error("count beyond canvas side");
endmodule
`default_nettype wire
